@@ design/pspt_pkg.sv @@
// Package: sizes, command and status types for the stride prefetch table.
`default_nettype none
package pspt_pkg;

  localparam int TABLE_ENTRIES = 128;
  localparam int ADDR_W        = 48;
  localparam int STRIDE_W      = 32;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
  localparam int LANES         = (TABLE_ENTRIES >= 64) ? 32 : TABLE_ENTRIES / 2;
  localparam int ROWS          = TABLE_ENTRIES / LANES;
  localparam int LANE_W        = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int ROW_W         = (ROWS > 1) ? $clog2(ROWS) : 1;

  typedef struct packed {
    logic capture;
    logic srch;
    logic alloc;
    logic calc;
    logic commit;
  } ctl_cmd_t;

  typedef struct packed {
    logic row_last;
    logic hit_eq;
    logic out_busy;
  } ctl_sts_t;

endpackage
`default_nettype wire

@@ design/pc_stride_prefetch_table.sv @@
// Top level: PC-indexed stride prefetch table.
//
// Input channel (in_*): one cache access per transaction. An access with
// in_is_miss low is absorbed in its accept cycle and in_ready stays high.
// A miss looks up in_pc_value in a 128-entry fully associative table,
// allocating in FIFO order when absent, and updates the entry's stride and
// last address. When the new stride equals the stored one, one prefetch
// address goes out on the result channel (out_*); otherwise nothing.
// Sequencing: a miss holds in_ready low from its accept until its commit, so
// no new access is taken while a miss is in flight. The tag scan reads the
// 4 rows of 32 tags one row at a time, a further step compares the last row,
// then the entry is read, the stride computed and the result committed. The
// prefetch is registered at the commit and then shows on out_valid.
// The result sits in an output register; a new access is taken while it
// waits. If the receiver still stalls when the next prefetch is ready, the
// commit holds until out_ready frees the register.
// Reset (rst_n low, synchronous) empties the table, zeroes the FIFO
// pointer and drops any pending result. No clearing pass is needed.
`default_nettype none
module pc_stride_prefetch_table
  import pspt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_is_miss,
  input  wire logic [ADDR_W-1:0] in_pc_value,
  input  wire logic [ADDR_W-1:0] in_mem_address,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [ADDR_W-1:0]      out_prefetch_address
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  pspt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_is_miss (in_is_miss),
    .in_ready   (in_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  pspt_dpath u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_pc_value          (in_pc_value),
    .in_mem_address       (in_mem_address),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_ready            (out_ready),
    .out_valid            (out_valid),
    .out_prefetch_address (out_prefetch_address)
  );

endmodule
`default_nettype wire

@@ design/pspt_ctrl.sv @@
// Controller: sequences tag scan, entry read, stride compute and commit.
`default_nettype none
module pspt_ctrl
  import pspt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_is_miss,
  output logic          in_ready,
  input  wire ctl_sts_t sts,
  output ctl_cmd_t      cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRCH = 3'd1;
  localparam logic [2:0] S_LAST = 3'd2;
  localparam logic [2:0] S_DRD  = 3'd3;
  localparam logic [2:0] S_CALC = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd         = '0;
    cmd.capture = (state_r == S_IDLE) && in_valid;
    cmd.srch    = (state_r == S_SRCH);
    cmd.alloc   = (state_r == S_DRD);
    cmd.calc    = (state_r == S_CALC);
    cmd.commit  = (state_r == S_EMIT) && !(sts.hit_eq && sts.out_busy);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_is_miss) state_nxt = S_SRCH;
      end
      S_SRCH: begin
        if (sts.row_last) state_nxt = S_LAST;
      end
      S_LAST: state_nxt = S_DRD;
      S_DRD:  state_nxt = S_CALC;
      S_CALC: state_nxt = S_EMIT;
      S_EMIT: begin
        if (cmd.commit) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

@@ design/pspt_dpath.sv @@
// Datapath: tag lanes, entry memories, FIFO pointer, stride math, output register.
`default_nettype none
module pspt_dpath
  import pspt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [ADDR_W-1:0] in_pc_value,
  input  wire logic [ADDR_W-1:0] in_mem_address,
  input  wire ctl_cmd_t          cmd,
  output ctl_sts_t               sts,
  input  wire logic              out_ready,
  output logic                   out_valid,
  output logic [ADDR_W-1:0]      out_prefetch_address
);

  logic [ADDR_W-1:0]   pc_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [ROW_W-1:0]    row_r;
  logic [ROW_W-1:0]    rd_row_r;
  logic                cmp_vld_r;
  logic                hit_r;
  logic [IDX_W-1:0]    hit_slot_r;
  logic [IDX_W-1:0]    slot_r;
  logic [CNT_W-1:0]    count_r;
  logic [IDX_W-1:0]    oldest_r;
  logic [STRIDE_W-1:0] new_stride_r;
  logic [STRIDE_W-1:0] stride_r;
  logic                eq_r;
  logic                out_valid_r;
  logic [ADDR_W-1:0]   out_addr_r;

  logic [ADDR_W-1:0]   last_q;
  logic [STRIDE_W-1:0] stride_q;
  logic [ADDR_W-1:0]   last_mem   [TABLE_ENTRIES];
  logic [STRIDE_W-1:0] stride_mem [TABLE_ENTRIES];

  logic [LANES-1:0]    match;
  logic [LANE_W-1:0]   match_lane;
  logic [IDX_W-1:0]    slot_sel;
  logic [ROW_W-1:0]    alloc_row;
  logic [LANE_W-1:0]   alloc_lane;
  logic                tag_we;
  logic [ADDR_W-1:0]   last_v;
  logic [STRIDE_W-1:0] stride_v;
  logic [STRIDE_W-1:0] diff_v;

  assign slot_sel   = hit_r ? hit_slot_r : oldest_r;
  assign alloc_row  = ROW_W'(oldest_r / LANES);
  assign alloc_lane = LANE_W'(oldest_r % LANES);
  assign tag_we     = cmd.alloc && !hit_r;

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    logic [ADDR_W-1:0] mem [ROWS];
    logic [ADDR_W-1:0] tag_q;
    logic [IDX_W-1:0]  gidx;

    always_ff @(posedge clk) begin
      if (tag_we && (alloc_lane == LANE_W'(j))) mem[alloc_row] <= pc_r;
      if (cmd.srch) tag_q <= mem[row_r];
    end

    assign gidx     = IDX_W'(rd_row_r) * IDX_W'(LANES) + IDX_W'(j);
    assign match[j] = (tag_q == pc_r) && (CNT_W'(gidx) < count_r);
  end

  always_comb begin
    match_lane = '0;
    for (int j = 0; j < LANES; j++) begin
      if (match[j]) match_lane = match_lane | LANE_W'(j);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc) begin
      last_q   <= last_mem[slot_sel];
      stride_q <= stride_mem[slot_sel];
    end
    if (cmd.commit) begin
      last_mem[slot_r]   <= addr_r;
      stride_mem[slot_r] <= new_stride_r;
    end
  end

  assign last_v   = hit_r ? last_q : '0;
  assign stride_v = hit_r ? stride_q : '0;
  assign diff_v   = addr_r[STRIDE_W-1:0] - last_v[STRIDE_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pc_r   <= in_pc_value;
      addr_r <= in_mem_address;
    end
    if (cmd.srch) rd_row_r <= row_r;
    if (cmd.alloc) slot_r <= slot_sel;
    if (cmd.calc) begin
      new_stride_r <= diff_v;
      stride_r     <= stride_v;
      eq_r         <= (diff_v == stride_v);
    end
    if (cmd.commit && eq_r) begin
      out_addr_r <= addr_r + {{(ADDR_W - STRIDE_W){stride_r[STRIDE_W-1]}}, stride_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      cmp_vld_r   <= 1'b0;
      hit_r       <= 1'b0;
      hit_slot_r  <= '0;
      count_r     <= '0;
      oldest_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cmp_vld_r <= cmd.srch;
      if (cmd.capture) begin
        row_r <= '0;
        hit_r <= 1'b0;
      end else if (cmd.srch) begin
        row_r <= row_r + ROW_W'(1);
      end
      if (cmp_vld_r && (|match)) begin
        hit_r      <= 1'b1;
        hit_slot_r <= IDX_W'(rd_row_r) * IDX_W'(LANES) + IDX_W'(match_lane);
      end
      if (tag_we) begin
        oldest_r <= (oldest_r == IDX_W'(TABLE_ENTRIES - 1)) ? '0 : oldest_r + IDX_W'(1);
        if (count_r < CNT_W'(TABLE_ENTRIES)) count_r <= count_r + CNT_W'(1);
      end
      if (cmd.commit && eq_r) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts          = '0;
    sts.row_last = (row_r == ROW_W'(ROWS - 1));
    sts.hit_eq   = eq_r;
    sts.out_busy = out_valid_r && !out_ready;
  end

  assign out_valid            = out_valid_r;
  assign out_prefetch_address = out_addr_r;

endmodule
`default_nettype wire

@@ design/pspt_checker.sv @@
// Checker: port-level properties of the stride prefetch table, bound to the top.
`default_nettype none
module pspt_checker
  import pspt_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              in_is_miss,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [ADDR_W-1:0] out_prefetch_address
);

  a_miss_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_is_miss |=> !in_ready)
    else $error("in_ready high right after a miss transaction");

  a_hit_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_is_miss |=> in_ready)
    else $error("in_ready dropped after a hit transaction");

  a_out_from_miss: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("prefetch issued without a miss in progress");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_prefetch_address))
    else $error("stalled prefetch transaction changed");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

endmodule

bind pc_stride_prefetch_table pspt_checker u_pspt_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_ready             (in_ready),
  .in_is_miss           (in_is_miss),
  .out_valid            (out_valid),
  .out_ready            (out_ready),
  .out_prefetch_address (out_prefetch_address)
);
`default_nettype wire
